### design/gisu_pkg.sv
`default_nettype none

package gisu_pkg;

   localparam int SITE_WIDTH     = 10;
   localparam int SLOT_WIDTH     = 3;
   localparam int CMD_WIDTH      = 2;
   localparam int RANDOM_WIDTH   = 32;
   localparam int COUNT_WIDTH    = 3;
   localparam int THR_COUNT      = 8;
   localparam int THR_WIDTH      = 33;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [THR_WIDTH-1:0] THR_RESET = 33'h0_8000_0000;

   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_NEIGHBOR = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LOAD_SPIN     = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_UPDATE        = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_END_SWEEP     = 2'd3;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]    command;
      logic [SITE_WIDTH-1:0]   site;
      logic [SLOT_WIDTH-1:0]   slot;
      logic [SITE_WIDTH-1:0]   load_value;
      logic [RANDOM_WIDTH-1:0] random_fraction;
   } gisu_req_type;

   typedef struct packed {
      logic [SITE_WIDTH-1:0]  updated_site;
      logic                   new_spin;
      logic [COUNT_WIDTH-1:0] up_count;
   } gisu_rsp_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  up_count;
      logic [RANDOM_WIDTH-1:0] random_fraction;
   } gisu_decide_req_type;

endpackage

`default_nettype wire

### design/gisu_ram.sv
`default_nettype none

module gisu_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

### design/gisu_decide.sv
`default_nettype none

module gisu_decide
   import gisu_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [THR_WIDTH-1:0]       csr_write_data,
   input  wire gisu_decide_req_type        decide_req,
   output logic                            new_spin
);

   logic [THR_WIDTH-1:0] thr_ff [THR_COUNT];
   logic [THR_WIDTH-1:0] thr_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < THR_COUNT; k++) begin
            thr_ff[k] <= THR_RESET;
         end
      end else if (csr_write_enable) begin
         thr_ff[csr_index] <= csr_write_data;
      end
   end

   assign thr_sel  = thr_ff[decide_req.up_count];
   assign new_spin = {1'b0, decide_req.random_fraction} < thr_sel;

endmodule

`default_nettype wire

### design/glauber_ising_site_update.sv
// Synchronous Glauber heat-bath update of binary spins on a regular graph.
// After reset the block clears both spin banks, one site a cycle, and keeps
// busy high until the clear is done. A beat is taken when start is high and
// busy is low. Neighbor loads, spin loads and end-of-sweep beats finish in
// the cycle they are taken and busy stays low. An update beat keeps busy high
// until its decide step is done, so the next update waits for it: for each
// neighbor the block reads its index from the neighbor table and then its spin
// from the current bank, after which a final step sums and a decide step
// compares against the threshold. The result is shown on rsp_payload for
// exactly one cycle with rsp_strobe, in the cycle busy falls; it must be
// taken then, as the block cannot be held off. An update of a site at or
// above SITES gives no result. Thresholds may only be written while idle.
`default_nettype none

module glauber_ising_site_update
   import gisu_pkg::*;
#(
   parameter int SITES     = 1024,
   parameter int NEIGHBORS = 3
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire gisu_req_type               req_payload,
   output logic                            rsp_strobe,
   output gisu_rsp_type                    rsp_payload,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [THR_WIDTH-1:0]       csr_write_data
);

   localparam int SA = $clog2(SITES);
   localparam int NA = $clog2(SITES * NEIGHBORS);
   localparam int NW = $clog2(NEIGHBORS + 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_NBR    = 3'd2;
   localparam logic [2:0] S_SPIN   = 3'd3;
   localparam logic [2:0] S_FINAL  = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;

   logic [2:0]              state_ff;
   logic [2:0]              state_in;
   logic [SA-1:0]           clear_addr_ff;
   logic                    current_bank_ff;
   logic [SITE_WIDTH-1:0]   site_ff;
   logic [SA-1:0]           site_addr_ff;
   logic [RANDOM_WIDTH-1:0] rnd_ff;
   logic [NA-1:0]           nbr_addr_ff;
   logic [NW-1:0]           nbr_index_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic                    pending_ff;
   logic                    rsp_strobe_ff;
   gisu_rsp_type            rsp_ff;

   logic                    accept;
   logic [31:0]             site_wide;
   logic [31:0]             nbr_wide;
   logic                    site_ok;
   logic                    slot_ok;
   logic                    nbr_ok;
   logic [SITE_WIDTH-1:0]   nbr_rd;
   logic                    nbr_we;
   logic [NA-1:0]           nbr_waddr;
   logic                    spin_a_rd;
   logic                    spin_b_rd;
   logic                    spin_rd;
   logic [SA-1:0]           spin_raddr;
   logic                    a_we;
   logic                    b_we;
   logic [SA-1:0]           spin_waddr;
   logic                    spin_wdata;
   logic                    decided_spin;
   gisu_decide_req_type     decide_req;

   assign busy      = state_ff != S_IDLE;
   assign accept    = start && !busy;
   assign site_wide = 32'(req_payload.site);
   assign nbr_wide  = 32'(nbr_rd);
   assign site_ok   = site_wide < SITES;
   assign slot_ok   = 32'(req_payload.slot) < NEIGHBORS;
   assign nbr_ok    = nbr_wide < SITES;
   assign spin_rd   = current_bank_ff ? spin_b_rd : spin_a_rd;
   assign count_in  = count_ff + COUNT_WIDTH'(pending_ff & spin_rd);

   assign nbr_we    = accept && req_payload.command == CMD_LOAD_NEIGHBOR && site_ok && slot_ok;
   assign nbr_waddr = NA'(site_wide * NEIGHBORS + 32'(req_payload.slot));

   assign spin_raddr = (state_ff == S_SPIN) ? nbr_wide[SA-1:0] : site_wide[SA-1:0];

   always_comb begin
      a_we       = 1'b0;
      b_we       = 1'b0;
      spin_waddr = site_wide[SA-1:0];
      spin_wdata = req_payload.load_value[0];
      if (state_ff == S_CLEAR) begin
         a_we       = 1'b1;
         b_we       = 1'b1;
         spin_waddr = clear_addr_ff;
         spin_wdata = 1'b0;
      end else if (state_ff == S_DECIDE) begin
         a_we       = current_bank_ff;
         b_we       = !current_bank_ff;
         spin_waddr = site_addr_ff;
         spin_wdata = decided_spin;
      end else if (accept && req_payload.command == CMD_LOAD_SPIN && site_ok) begin
         a_we = !current_bank_ff;
         b_we = current_bank_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_addr_ff == SA'(SITES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_payload.command == CMD_UPDATE && site_ok) begin
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            state_in = S_SPIN;
         end
         S_SPIN: begin
            if (nbr_index_ff == NW'(NEIGHBORS - 1)) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_NBR;
            end
         end
         S_FINAL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clear_addr_ff   <= '0;
         current_bank_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         pending_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= state_ff == S_DECIDE;
         if (state_ff == S_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + SA'(1);
         end
         if (accept && req_payload.command == CMD_END_SWEEP) begin
            current_bank_ff <= !current_bank_ff;
         end
         if (state_ff == S_IDLE) begin
            pending_ff <= 1'b1;
         end else if (state_ff == S_SPIN) begin
            pending_ff <= nbr_ok;
         end else if (state_ff == S_NBR || state_ff == S_FINAL) begin
            pending_ff <= 1'b0;
         end
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         site_ff      <= req_payload.site;
         site_addr_ff <= site_wide[SA-1:0];
         rnd_ff       <= req_payload.random_fraction;
         nbr_addr_ff  <= NA'(site_wide * NEIGHBORS);
         nbr_index_ff <= '0;
         count_ff     <= '0;
      end else if (state_ff == S_NBR || state_ff == S_FINAL) begin
         count_ff <= count_in;
      end else if (state_ff == S_SPIN) begin
         nbr_addr_ff  <= nbr_addr_ff + NA'(1);
         nbr_index_ff <= nbr_index_ff + NW'(1);
      end
      if (state_ff == S_DECIDE) begin
         rsp_ff.updated_site <= site_ff;
         rsp_ff.new_spin     <= decided_spin;
         rsp_ff.up_count     <= count_ff;
      end
   end

   assign decide_req.up_count        = count_ff;
   assign decide_req.random_fraction = rnd_ff;

   gisu_decide u_decide (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .decide_req       (decide_req),
      .new_spin         (decided_spin)
   );

   gisu_ram #(
      .WIDTH (SITE_WIDTH),
      .DEPTH (SITES * NEIGHBORS)
   ) u_nbr_ram (
      .clock         (clock),
      .write_enable  (nbr_we),
      .write_address (nbr_waddr),
      .write_data    (req_payload.load_value),
      .read_address  (nbr_addr_ff),
      .read_data     (nbr_rd)
   );

   gisu_ram #(
      .WIDTH (1),
      .DEPTH (SITES)
   ) u_bank_a_ram (
      .clock         (clock),
      .write_enable  (a_we),
      .write_address (spin_waddr),
      .write_data    (spin_wdata),
      .read_address  (spin_raddr),
      .read_data     (spin_a_rd)
   );

   gisu_ram #(
      .WIDTH (1),
      .DEPTH (SITES)
   ) u_bank_b_ram (
      .clock         (clock),
      .write_enable  (b_we),
      .write_address (spin_waddr),
      .write_data    (spin_wdata),
      .read_address  (spin_raddr),
      .read_data     (spin_b_rd)
   );

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_strobe_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_DECIDE)
      else $error("result beat without a decide step");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats back to back");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.command == CMD_END_SWEEP) |=>
         current_bank_ff != $past(current_bank_ff))
      else $error("end of sweep did not swap banks");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> 32'(rsp_payload.up_count) <= NEIGHBORS + 1)
      else $error("up count above neighbor count plus one");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb
   import gisu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SITE_COUNT     = 1024;
   localparam int NEIGHBOR_COUNT = 3;
   localparam int CYCLE_LIMIT    = 400_000;
   localparam int IDLE_PAUSE     = 12;
   localparam int POOL_EXTRA     = 22;
   localparam int PHASES         = 7;
   localparam int SWEEPS_PER_PHASE = 3;
   localparam int BEATS_PER_SWEEP  = 20;

   localparam logic [THR_WIDTH-1:0] THR_ALWAYS_UP = 33'h1_0000_0000;
   localparam logic [THR_WIDTH-1:0] THR_TOP       = 33'h1_FFFF_FFFF;
   localparam logic [THR_WIDTH-1:0] THR_FULL_32   = 33'h0_FFFF_FFFF;

   typedef enum int {
      THR_DIRECTED,
      THR_RANDOM,
      THR_ALL_DOWN,
      THR_ALL_UP,
      THR_MIXED
   } threshold_plan_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   gisu_req_type               req_payload = '0;
   logic                       rsp_strobe;
   gisu_rsp_type               rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [THR_WIDTH-1:0]       csr_write_data = '0;

   // lattice state as the block should hold it
   logic [THR_WIDTH-1:0]  threshold_reg [THR_COUNT];
   logic [SITE_WIDTH-1:0] neighbor_of [SITE_COUNT*NEIGHBOR_COUNT];
   bit                    spin_bank [2][SITE_COUNT];
   bit                    front_bank = 1'b0;

   gisu_req_type command_queue [$];
   gisu_rsp_type expected_spins [$];
   gisu_rsp_type oldest_spin;

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  gap_left = 0;
   bit  gaps_on = 1'b1;

   glauber_ising_site_update #(
      .SITES     (SITE_COUNT),
      .NEIGHBORS (NEIGHBOR_COUNT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < THR_COUNT; k++) begin
         threshold_reg[k] = THR_RESET;
      end
      for (int i = 0; i < SITE_COUNT*NEIGHBOR_COUNT; i++) begin
         neighbor_of[i] = '0;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[cycle %0d] mismatch: %s", cycle_count, what);
   endtask

   // one accepted beat moves the lattice state and may yield one spin
   function automatic void apply_command(input gisu_req_type beat);
      logic [COUNT_WIDTH-1:0] ups;
      logic [SITE_WIDTH-1:0]  nbr;
      gisu_rsp_type           outcome;
      case (beat.command)
         CMD_LOAD_NEIGHBOR: begin
            if (beat.site < SITE_COUNT && beat.slot < NEIGHBOR_COUNT)
               neighbor_of[beat.site*NEIGHBOR_COUNT + beat.slot] = beat.load_value;
         end
         CMD_LOAD_SPIN: begin
            if (beat.site < SITE_COUNT)
               spin_bank[front_bank][beat.site] = beat.load_value[0];
         end
         CMD_UPDATE: begin
            if (beat.site < SITE_COUNT) begin
               ups = COUNT_WIDTH'(spin_bank[front_bank][beat.site]);
               for (int j = 0; j < NEIGHBOR_COUNT; j++) begin
                  nbr = neighbor_of[beat.site*NEIGHBOR_COUNT + j];
                  if (nbr < SITE_COUNT)
                     ups = ups + COUNT_WIDTH'(spin_bank[front_bank][nbr]);
               end
               outcome.updated_site = beat.site;
               outcome.new_spin = ({1'b0, beat.random_fraction} < threshold_reg[ups]);
               outcome.up_count = ups;
               spin_bank[front_bank ^ 1'b1][beat.site] = outcome.new_spin;
               expected_spins.push_back(outcome);
            end
         end
         CMD_END_SWEEP: begin
            front_bank = ~front_bank;
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_command(input logic [CMD_WIDTH-1:0]    cmd,
                                input logic [SITE_WIDTH-1:0]   site,
                                input logic [SLOT_WIDTH-1:0]   slot,
                                input logic [SITE_WIDTH-1:0]   value,
                                input logic [RANDOM_WIDTH-1:0] fraction);
      gisu_req_type beat;
      beat.command = cmd;
      beat.site = site;
      beat.slot = slot;
      beat.load_value = value;
      beat.random_fraction = fraction;
      command_queue.push_back(beat);
   endtask

   task automatic wait_until_idle();
      do
         @(posedge clock);
      while (command_queue.size() != 0 || start || busy !== 1'b0 ||
             expected_spins.size() != 0);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic program_thresholds(input threshold_plan_type plan);
      logic [THR_WIDTH-1:0] value;
      for (int k = 0; k < THR_COUNT; k++) begin
         case (plan)
            THR_DIRECTED: begin
               case (k)
                  0: value = '0;
                  1: value = THR_ALWAYS_UP;
                  2: value = THR_TOP;
                  3: value = THR_FULL_32;
                  4: value = 33'd1;
                  default: value = {1'b0, $urandom};
               endcase
            end
            THR_RANDOM:   value = {1'b0, $urandom};
            THR_ALL_DOWN: value = '0;
            THR_ALL_UP:   value = (k % 2 == 0) ? THR_ALWAYS_UP : THR_TOP;
            default: begin
               case ($urandom_range(0, 7))
                  0: value = '0;
                  1: value = 33'd1;
                  2: value = THR_FULL_32;
                  3: value = THR_ALWAYS_UP;
                  4: value = THR_TOP;
                  5: value = THR_RESET;
                  6: value = {1'b0, $urandom};
                  default: value = {1'b1, $urandom};
               endcase
            end
         endcase
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(k);
         csr_write_data <= value;
         threshold_reg[k] = value;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            apply_command(req_payload);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (command_queue.size() > 0) begin
               start <= 1'b1;
               req_payload <= command_queue.pop_front();
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_spins.size() == 0) begin
            report_mismatch($sformatf("unexpected result for site %0d",
                                      rsp_payload.updated_site));
         end else begin
            oldest_spin = expected_spins.pop_front();
            if (rsp_payload.updated_site !== oldest_spin.updated_site)
               report_mismatch($sformatf("updated_site got %0d want %0d",
                                         rsp_payload.updated_site,
                                         oldest_spin.updated_site));
            if (rsp_payload.new_spin !== oldest_spin.new_spin)
               report_mismatch($sformatf("site %0d new_spin got %0b want %0b",
                                         oldest_spin.updated_site,
                                         rsp_payload.new_spin, oldest_spin.new_spin));
            if (rsp_payload.up_count !== oldest_spin.up_count)
               report_mismatch($sformatf("site %0d up_count got %0d want %0d",
                                         oldest_spin.updated_site,
                                         rsp_payload.up_count, oldest_spin.up_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("glauber_ising_site_update verification failed");
         $finish;
      end
   end

   initial begin
      logic [SITE_WIDTH-1:0]   pool_sites [$];
      logic [SITE_WIDTH-1:0]   site;
      logic [SITE_WIDTH-1:0]   value;
      logic [RANDOM_WIDTH-1:0] fraction;
      threshold_plan_type      plans [PHASES];
      int                      r;

      plans = '{THR_MIXED, THR_RANDOM, THR_ALL_DOWN, THR_MIXED,
                THR_ALL_UP, THR_RANDOM, THR_MIXED};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_until_idle();

      // directed: thresholds still at reset
      queue_command(CMD_LOAD_NEIGHBOR, 10'd0, 3'd0, 10'd1023, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd0, 3'd1, 10'd1, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd0, 3'd2, 10'd2, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd0, 3'd3, 10'd5, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd0, 3'd7, 10'd9, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd1023, 3'd0, 10'd0, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd1023, 3'd1, 10'd1023, $urandom);
      queue_command(CMD_LOAD_NEIGHBOR, 10'd1023, 3'd2, 10'd1, $urandom);
      queue_command(CMD_UPDATE, 10'd0, 3'd7, 10'd1023, 32'h0000_0000);
      queue_command(CMD_UPDATE, 10'd1023, 3'd0, 10'd0, 32'hFFFF_FFFF);
      wait_until_idle();

      // directed: extreme thresholds
      program_thresholds(THR_DIRECTED);
      queue_command(CMD_LOAD_SPIN, 10'd1023, 3'd5, 10'd1023, $urandom);
      queue_command(CMD_LOAD_SPIN, 10'd1, 3'd0, 10'd1, $urandom);
      queue_command(CMD_LOAD_SPIN, 10'd2, 3'd0, 10'h3FE, $urandom);
      queue_command(CMD_LOAD_SPIN, 10'd0, 3'd0, 10'd1, $urandom);
      queue_command(CMD_UPDATE, 10'd0, 3'd0, 10'd0, 32'hFFFF_FFFF);
      queue_command(CMD_UPDATE, 10'd0, 3'd0, 10'd0, 32'hFFFF_FFFE);
      queue_command(CMD_UPDATE, 10'd1023, 3'd0, 10'd0, 32'h0000_0000);
      queue_command(CMD_UPDATE, 10'd1023, 3'd0, 10'd0, 32'h0000_0001);
      queue_command(CMD_END_SWEEP, 10'd1023, 3'd7, 10'd1023, 32'hFFFF_FFFF);
      queue_command(CMD_UPDATE, 10'd0, 3'd0, 10'd0, 32'hFFFF_FFFF);
      queue_command(CMD_UPDATE, 10'd1023, 3'd7, 10'd1023, 32'h8000_0000);
      queue_command(CMD_LOAD_SPIN, 10'd2, 3'd0, 10'd1, $urandom);
      queue_command(CMD_END_SWEEP, 10'd0, 3'd0, 10'd0, 32'h0000_0000);
      queue_command(CMD_UPDATE, 10'd0, 3'd0, 10'd0, 32'h8000_0000);

      // neighbor lists and spins for a pool of sites, wired mostly among themselves
      pool_sites = '{10'd0, 10'd1023};
      repeat (POOL_EXTRA)
         pool_sites.push_back(SITE_WIDTH'($urandom_range(1, SITE_COUNT - 2)));
      foreach (pool_sites[i]) begin
         for (int slot = 0; slot < NEIGHBOR_COUNT; slot++) begin
            if ($urandom_range(0, 99) < 85)
               value = pool_sites[$urandom_range(0, pool_sites.size() - 1)];
            else
               value = SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1));
            queue_command(CMD_LOAD_NEIGHBOR, pool_sites[i], SLOT_WIDTH'(slot), value,
                          $urandom);
         end
      end
      foreach (pool_sites[i])
         queue_command(CMD_LOAD_SPIN, pool_sites[i], SLOT_WIDTH'($urandom_range(0, 7)),
                       SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)), $urandom);
      wait_until_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         program_thresholds(plans[phase]);
         gaps_on = (phase % 3 != 1);
         repeat (SWEEPS_PER_PHASE) begin
            repeat (BEATS_PER_SWEEP) begin
               r = $urandom_range(0, 99);
               site = pool_sites[$urandom_range(0, pool_sites.size() - 1)];
               if (r < 8) begin
                  queue_command(CMD_LOAD_SPIN,
                                ($urandom_range(0, 1) != 0) ? site
                                   : SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                                SLOT_WIDTH'($urandom_range(0, 7)),
                                SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                                $urandom);
               end else if (r < 12) begin
                  queue_command(CMD_LOAD_NEIGHBOR, site,
                                SLOT_WIDTH'($urandom_range(0, NEIGHBOR_COUNT - 1)),
                                pool_sites[$urandom_range(0, pool_sites.size() - 1)],
                                $urandom);
               end else if (r < 16) begin
                  // slot beyond the list: must leave the table alone
                  queue_command(CMD_LOAD_NEIGHBOR, site,
                                SLOT_WIDTH'($urandom_range(NEIGHBOR_COUNT, 7)),
                                SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)), $urandom);
               end else if (r < 18) begin
                  queue_command(CMD_END_SWEEP,
                                SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                                SLOT_WIDTH'($urandom_range(0, 7)),
                                SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                                $urandom);
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 70) begin
                     fraction = $urandom;
                  end else if (r < 85) begin
                     case ($urandom_range(0, 3))
                        0: fraction = 32'h0000_0000;
                        1: fraction = 32'h0000_0001;
                        2: fraction = 32'hFFFF_FFFF;
                        default: fraction = 32'h8000_0000;
                     endcase
                  end else begin
                     // straddle the threshold of a reachable count
                     fraction = threshold_reg[$urandom_range(0, NEIGHBOR_COUNT + 1)]
                                   [RANDOM_WIDTH-1:0];
                     fraction = fraction + $urandom_range(0, 2) - 1;
                  end
                  queue_command(CMD_UPDATE, site, SLOT_WIDTH'($urandom_range(0, 7)),
                                SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)), fraction);
               end
            end
            queue_command(CMD_END_SWEEP, SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                          SLOT_WIDTH'($urandom_range(0, 7)),
                          SITE_WIDTH'($urandom_range(0, SITE_COUNT - 1)),
                          $urandom);
         end
         wait_until_idle();
      end

      if (mismatch_count == 0)
         $display("glauber_ising_site_update verification clean");
      else
         $display("glauber_ising_site_update verification failed");
      $finish;
   end

endmodule

`default_nettype wire

### glauber_ising_site_update.f
design/gisu_pkg.sv
design/gisu_ram.sv
design/gisu_decide.sv
design/glauber_ising_site_update.sv
test/tb.sv
